// File: src/i2p_pkg.sv
// Shared types, token codes and the precedence table of the infix to postfix converter.
// Used by every module of the block except i2p_queue; depends on nothing.
package i2p_pkg;

  // Widths of the stream fields
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned TAG_FIELD_W = 16;
  localparam int unsigned OUT_KIND_W = 2;
  localparam int unsigned ERR_W      = 2;
  localparam int unsigned DATA_W     = 24;

  // Input token kinds
  localparam logic [KIND_W-1:0] KIND_OPERAND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LPAREN  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RPAREN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OPER    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END     = 3'd4;

  // Operator codes, plus the stack mark for a left paren
  localparam logic [OP_W-1:0] OP_PLUS   = 3'd0;
  localparam logic [OP_W-1:0] OP_MINUS  = 3'd1;
  localparam logic [OP_W-1:0] OP_TIMES  = 3'd2;
  localparam logic [OP_W-1:0] OP_DIVIDE = 3'd3;
  localparam logic [OP_W-1:0] OP_POWER  = 3'd4;
  localparam logic [OP_W-1:0] OP_FACT   = 3'd5;
  localparam logic [OP_W-1:0] PAREN_MARK = 3'd6;

  // Result kinds
  localparam logic [OUT_KIND_W-1:0] OUT_OPERAND  = 2'd0;
  localparam logic [OUT_KIND_W-1:0] OUT_OPERATOR = 2'd1;
  localparam logic [OUT_KIND_W-1:0] OUT_ERROR    = 2'd2;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RPAREN   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_LPAREN   = 2'd3;

  // Command classes passed from front to back
  typedef enum logic [2:0] {
    CMD_OPERAND,
    CMD_LPAREN,
    CMD_RPAREN,
    CMD_OPERATOR,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic [OP_W-1:0] op;
    logic [1:0]      prec;
    logic            right_assoc;
  } cmd_t;

  typedef struct packed {
    logic [OUT_KIND_W-1:0] kind;
    logic [OP_W-1:0]       op;
    logic                  negated;
    logic [ERR_W-1:0]      err;
  } res_t;

  // + - lowest, then * /, then ^, then !
  function automatic logic [1:0] prec_of(input logic [OP_W-1:0] op);
    logic [1:0] p;
    if (op <= OP_MINUS) begin
      p = 2'd0;
    end else if (op <= OP_DIVIDE) begin
      p = 2'd1;
    end else if (op == OP_POWER) begin
      p = 2'd2;
    end else begin
      p = 2'd3;
    end
    return p;
  endfunction

endpackage

// File: src/infix_to_postfix_converter.sv
// Infix to postfix converter (shunting yard): front classifier, command queue, stack back end.
// With the back end idle, an operand beat passes the command queue, the command register and
// the output register before m_axis_tvalid rises. The back end takes one command at a time and
// finishes its popped operators, discarded left parens and error beat first; output stalls hold it.
// Reset: rst (synchronous) clears the queue, sequencer, stack pointer and unary state;
// stack contents are left as they are and never read before they are written.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned TAG_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [2:0] op_code, [18:3] operand_tag, [23:19] zero
  input  logic [2:0]  s_axis_tuser,  // [2:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [2:0] out_op, [18:3] out_tag, [19] negated,
                                     // [21:20] error_code, [23:22] zero
  output logic [1:0]  m_axis_tuser,  // [1:0] out_kind
  output logic        m_axis_tlast   // last
);

  localparam int unsigned TW    = (TAG_WIDTH < i2p_pkg::TAG_FIELD_W) ? TAG_WIDTH
                                                                     : i2p_pkg::TAG_FIELD_W;
  localparam int unsigned CMD_W = $bits(i2p_pkg::cmd_t);
  localparam int unsigned Q_W   = CMD_W + TW;

  logic          q_full, q_push, q_valid, q_pop;
  i2p_pkg::cmd_t f_cmd;
  logic [TW-1:0] f_tag;
  logic [Q_W-1:0] q_rdata;
  i2p_pkg::res_t m_res;
  logic [TW-1:0] m_tag;

  // Classify incoming beats
  i2p_front #(.TW(TW)) u_front (
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_kind  (s_axis_tuser),
    .in_op    (s_axis_tdata[2:0]),
    .in_tag   (s_axis_tdata[18:3]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (f_cmd),
    .q_tag    (f_tag)
  );

  // Decouple front and back
  i2p_queue #(.WIDTH(Q_W)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_cmd, f_tag}),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // Stack machine and output register
  i2p_back #(.STACK_DEPTH(STACK_DEPTH), .TW(TW)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (i2p_pkg::cmd_t'(q_rdata[Q_W-1 -: CMD_W])),
    .q_tag   (q_rdata[TW-1:0]),
    .q_pop   (q_pop),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_res   (m_res),
    .m_tag   (m_tag),
    .m_last  (m_axis_tlast)
  );

  // Pack the result beat
  assign m_axis_tuser = m_res.kind;
  assign m_axis_tdata = {2'b00, m_res.err, m_res.negated,
                         i2p_pkg::TAG_FIELD_W'(m_tag), m_res.op};

endmodule

// File: src/i2p_front.sv
// Front end: takes input beats, drops unknown tokens and classifies the rest into commands.
// Depends on i2p_pkg; feeds i2p_queue.
module i2p_front #(
  parameter int unsigned TW = 16
) (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [i2p_pkg::KIND_W-1:0]    in_kind,
  input  logic [i2p_pkg::OP_W-1:0]      in_op,
  input  logic [i2p_pkg::TAG_FIELD_W-1:0] in_tag,
  input  logic                          q_full,
  output logic                          q_push,
  output i2p_pkg::cmd_t                 q_cmd,
  output logic [TW-1:0]                 q_tag
);

  logic known;

  // Accept whenever the queue has room; unknown tokens are swallowed
  assign in_ready = !q_full;

  always_comb begin
    known = 1'b1;
    q_cmd = '0;
    q_cmd.op          = in_op;
    q_cmd.prec        = i2p_pkg::prec_of(in_op);
    q_cmd.right_assoc = (in_op == i2p_pkg::OP_POWER);
    unique case (in_kind)
      i2p_pkg::KIND_OPERAND: q_cmd.kind = i2p_pkg::CMD_OPERAND;
      i2p_pkg::KIND_LPAREN:  q_cmd.kind = i2p_pkg::CMD_LPAREN;
      i2p_pkg::KIND_RPAREN:  q_cmd.kind = i2p_pkg::CMD_RPAREN;
      i2p_pkg::KIND_OPER: begin
        q_cmd.kind = i2p_pkg::CMD_OPERATOR;
        known      = (in_op <= i2p_pkg::OP_FACT);
      end
      i2p_pkg::KIND_END:     q_cmd.kind = i2p_pkg::CMD_END;
      default:               known = 1'b0;
    endcase
  end

  assign q_tag  = TW'(in_tag);
  assign q_push = in_valid && !q_full && known;

endmodule

// File: src/i2p_queue.sv
// Two-entry command queue between the front and back ends.
// Generic width; no package dependency.
module i2p_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign rdata = slot[rd_ptr];

  // Payload slots
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && valid) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push && !full) - 2'(pop && valid);
    end
  end

endmodule

// File: src/i2p_back.sv
// Back end: operator stack, unary-minus state and result sequencing with an output register.
// Depends on i2p_pkg; takes commands from i2p_queue.
module i2p_back #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned TW          = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  i2p_pkg::cmd_t q_cmd,
  input  logic [TW-1:0] q_tag,
  output logic          q_pop,
  output logic          m_valid,
  input  logic          m_ready,
  output i2p_pkg::res_t m_res,
  output logic [TW-1:0] m_tag,
  output logic          m_last
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [1:0] {S_IDLE, S_WORK, S_FLUSH} state_t;

  state_t                   state;
  i2p_pkg::cmd_t            cur;
  logic [TW-1:0]            cur_tag;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [CW-1:0]            cnt_m1;
  logic                     unary;
  logic                     pending;
  logic                     open_paren;
  logic                     hold_valid;
  i2p_pkg::res_t            hold_res;
  logic [TW-1:0]            hold_tag;
  logic [i2p_pkg::OP_W-1:0] stack_mem [STACK_DEPTH];
  logic [i2p_pkg::OP_W-1:0] top_q;
  logic [AW-1:0]            rd_addr;

  logic                     out_free, has, top_paren, full, higher;
  logic [1:0]               top_prec;
  logic                     produce, done, push, pop, needs_out, stall, step, emit;
  logic [i2p_pkg::OP_W-1:0] push_val;
  i2p_pkg::res_t            new_res;
  logic [TW-1:0]            new_tag;
  logic                     unary_next, pending_next, open_next;

  assign out_free  = !m_valid || m_ready;
  assign has       = (count != '0);
  assign full      = (count == CW'(STACK_DEPTH));
  assign top_paren = (top_q == i2p_pkg::PAREN_MARK);
  assign top_prec  = i2p_pkg::prec_of(top_q);
  assign higher    = (top_prec > cur.prec) || ((top_prec == cur.prec) && !cur.right_assoc);
  assign q_pop     = (state == S_IDLE) && q_valid;

  // One step of the current command
  always_comb begin
    produce      = 1'b0;
    done         = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    push_val     = cur.op;
    new_res      = '0;
    new_tag      = '0;
    unary_next   = unary;
    pending_next = pending;
    open_next    = open_paren;
    unique case (cur.kind)
      i2p_pkg::CMD_OPERAND: begin
        produce         = 1'b1;
        done            = 1'b1;
        new_res.kind    = i2p_pkg::OUT_OPERAND;
        new_res.negated = pending;
        new_tag         = cur_tag;
        pending_next    = 1'b0;
        unary_next      = 1'b0;
      end
      i2p_pkg::CMD_LPAREN: begin
        done = 1'b1;
        if (full) begin
          produce      = 1'b1;
          new_res.kind = i2p_pkg::OUT_ERROR;
          new_res.err  = i2p_pkg::ERR_OVERFLOW;
        end else begin
          push       = 1'b1;
          push_val   = i2p_pkg::PAREN_MARK;
          unary_next = 1'b1;
        end
      end
      i2p_pkg::CMD_RPAREN: begin
        unary_next = 1'b0;
        if (!has) begin
          produce      = 1'b1;
          done         = 1'b1;
          new_res.kind = i2p_pkg::OUT_ERROR;
          new_res.err  = i2p_pkg::ERR_RPAREN;
        end else if (top_paren) begin
          pop  = 1'b1;
          done = 1'b1;
        end else begin
          pop          = 1'b1;
          produce      = 1'b1;
          new_res.kind = i2p_pkg::OUT_OPERATOR;
          new_res.op   = top_q;
        end
      end
      i2p_pkg::CMD_OPERATOR: begin
        if (cur.op == i2p_pkg::OP_MINUS && unary) begin
          pending_next = !pending;
          done         = 1'b1;
        end else if (has && !top_paren && higher) begin
          pop          = 1'b1;
          produce      = 1'b1;
          new_res.kind = i2p_pkg::OUT_OPERATOR;
          new_res.op   = top_q;
        end else if (full) begin
          produce      = 1'b1;
          done         = 1'b1;
          new_res.kind = i2p_pkg::OUT_ERROR;
          new_res.err  = i2p_pkg::ERR_OVERFLOW;
        end else begin
          push       = 1'b1;
          unary_next = 1'b1;
          done       = 1'b1;
        end
      end
      i2p_pkg::CMD_END: begin
        if (has) begin
          pop = 1'b1;
          if (top_paren) begin
            open_next = 1'b1;
          end else begin
            produce      = 1'b1;
            new_res.kind = i2p_pkg::OUT_OPERATOR;
            new_res.op   = top_q;
          end
        end else begin
          done         = 1'b1;
          pending_next = 1'b0;
          unary_next   = 1'b1;
          open_next    = 1'b0;
          if (open_paren) begin
            produce      = 1'b1;
            new_res.kind = i2p_pkg::OUT_ERROR;
            new_res.err  = i2p_pkg::ERR_LPAREN;
          end
        end
      end
      default: done = 1'b1;
    endcase
  end

  // A result waits in the hold slot until we know whether it is the last one
  always_comb begin
    priority case (state)
      S_WORK:  needs_out = hold_valid ? (produce || done) : (produce && done);
      S_FLUSH: needs_out = 1'b1;
      default: needs_out = 1'b0;
    endcase
    stall      = needs_out && !out_free;
    emit       = needs_out && !stall;
    step       = (state == S_WORK) && !stall;
    count_next = count + CW'(step && push) - CW'(step && pop);
    cnt_m1     = count_next - CW'(1);
    rd_addr    = cnt_m1[AW-1:0];
  end

  // Stack memory; the top entry is kept in a read register with write-through on push
  always_ff @(posedge clk) begin
    if (step && push) begin
      stack_mem[count[AW-1:0]] <= push_val;
      top_q                    <= push_val;
    end else begin
      top_q <= stack_mem[rd_addr];
    end
  end

  // Sequencer, stack pointer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      unary      <= 1'b1;
      pending    <= 1'b0;
      open_paren <= 1'b0;
      hold_valid <= 1'b0;
      m_valid    <= 1'b0;
    end else begin
      // Output beat: load on emit, clear once taken
      if (emit) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      count <= count_next;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur     <= q_cmd;
            cur_tag <= q_tag;
            state   <= S_WORK;
          end
        end
        S_WORK: begin
          if (!stall) begin
            unary      <= unary_next;
            pending    <= pending_next;
            open_paren <= open_next;
            if (hold_valid) begin
              if (produce || done) begin
                m_res  <= hold_res;
                m_tag  <= hold_tag;
                m_last <= done && !produce;
              end
              if (produce) begin
                hold_res <= new_res;
                hold_tag <= new_tag;
              end else if (done) begin
                hold_valid <= 1'b0;
              end
            end else if (produce && done) begin
              m_res  <= new_res;
              m_tag  <= new_tag;
              m_last <= 1'b1;
            end else if (produce) begin
              hold_valid <= 1'b1;
              hold_res   <= new_res;
              hold_tag   <= new_tag;
            end
            if (done) begin
              state <= (produce && hold_valid) ? S_FLUSH : S_IDLE;
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            m_res      <= hold_res;
            m_tag      <= hold_tag;
            m_last     <= 1'b1;
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Stack pointer stays within the stack
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // No result is left held once a command has finished
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !hold_valid)
    else $error("held result left behind");

  // The flush state always has a result to send
  a_flush_has_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_FLUSH |-> hold_valid)
    else $error("flush without held result");

  // An end command leaves the stack empty and the unary, negation and open-paren state as after reset
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (state == S_WORK && cur.kind == i2p_pkg::CMD_END && done && !stall)
      |=> (count == '0 && unary && !pending && !open_paren))
    else $error("end did not reset state");

endmodule

// File: bench/testbench.sv
// Self-checking bench for the infix to postfix converter: tokens in, postfix beats out.
// Depends on i2p_pkg and infix_to_postfix_converter; a built-in shunting-yard predictor
// supplies the expected beats.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned MAX_BURST   = STACK_DEPTH + 1;
  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned TOTAL_ITEMS = 100;
  // codes the block must ignore
  localparam logic [i2p_pkg::OP_W-1:0]   BAD_OP   = 3'd6;
  localparam logic [i2p_pkg::KIND_W-1:0] BAD_KIND = 3'd7;

  typedef struct packed {
    logic [i2p_pkg::KIND_W-1:0]      kind;
    logic [i2p_pkg::OP_W-1:0]        op;
    logic [i2p_pkg::TAG_FIELD_W-1:0] tag;
    logic                            hold;  // wait for every result before sending
    logic                            calm;  // no gap after this beat
  } token_t;

  typedef struct packed {
    logic [i2p_pkg::OUT_KIND_W-1:0]  kind;
    logic [i2p_pkg::OP_W-1:0]        op;
    logic [i2p_pkg::TAG_FIELD_W-1:0] tag;
    logic                            neg;
    logic [i2p_pkg::ERR_W-1:0]       err;
    logic                            last;
  } postfix_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [2:0] op_code, [18:3] operand_tag, [23:19] zero
  logic [2:0]  s_axis_tuser = '0;  // [2:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // [2:0] out_op, [18:3] out_tag, [19] negated,
                                   // [21:20] error_code, [23:22] zero
  logic [1:0]  m_axis_tuser;       // [1:0] out_kind
  logic        m_axis_tlast;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH),
    .TAG_WIDTH  (i2p_pkg::TAG_FIELD_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Free-running cycle count for the watchdog
  int unsigned cycle_n = 0;
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: operator stack and unary-minus tracking
  // ---------------------------------------------------------------------------
  logic [i2p_pkg::OP_W-1:0] op_stk [STACK_DEPTH];
  int unsigned              stk_n;
  logic                     unary_ok;
  logic                     neg_pending;

  postfix_t    postfix_q [$];      // beats still owed by the block
  int unsigned predicted_n = 0;    // beats ever predicted
  int unsigned drained_n   = 0;    // beats ever matched against a prediction
  int          fail_n      = 0;

  function automatic void clear_predictor();
    stk_n       = 0;
    unary_ok    = 1'b1;
    neg_pending = 1'b0;
  endfunction

  // + - bind loosest, ! tightest
  function automatic logic [1:0] binding_strength(input logic [i2p_pkg::OP_W-1:0] op);
    case (op)
      i2p_pkg::OP_PLUS, i2p_pkg::OP_MINUS:   return 2'd0;
      i2p_pkg::OP_TIMES, i2p_pkg::OP_DIVIDE: return 2'd1;
      i2p_pkg::OP_POWER:                     return 2'd2;
      default:                               return 2'd3;
    endcase
  endfunction

  function automatic postfix_t shape(input logic [i2p_pkg::OUT_KIND_W-1:0] kind,
                                     input logic [i2p_pkg::OP_W-1:0] op,
                                     input logic [i2p_pkg::TAG_FIELD_W-1:0] tag,
                                     input logic neg, input logic [i2p_pkg::ERR_W-1:0] err);
    postfix_t r;
    r.kind = kind;
    r.op   = op;
    r.tag  = tag;
    r.neg  = neg;
    r.err  = err;
    r.last = 1'b0;
    return r;
  endfunction

  // Advances the predictor by one token, queues its beats and returns their number
  function automatic int unsigned convert_token(input logic [i2p_pkg::KIND_W-1:0] kind,
                                                input logic [i2p_pkg::OP_W-1:0] op,
                                                input logic [i2p_pkg::TAG_FIELD_W-1:0] tag);
    postfix_t                 burst [MAX_BURST];
    int unsigned              n;
    logic [i2p_pkg::OP_W-1:0] top;
    logic                     stop;
    logic                     open_seen;
    n         = 0;
    stop      = 1'b0;
    open_seen = 1'b0;
    case (kind)
      i2p_pkg::KIND_OPERAND: begin
        burst[n] = shape(i2p_pkg::OUT_OPERAND, '0, tag, neg_pending, i2p_pkg::ERR_NONE);
        n++;
        neg_pending = 1'b0;
        unary_ok    = 1'b0;
      end
      i2p_pkg::KIND_LPAREN: begin
        if (stk_n >= STACK_DEPTH) begin
          burst[n] = shape(i2p_pkg::OUT_ERROR, '0, '0, 1'b0, i2p_pkg::ERR_OVERFLOW);
          n++;
        end else begin
          op_stk[stk_n] = i2p_pkg::PAREN_MARK;
          stk_n++;
          unary_ok = 1'b1;
        end
      end
      i2p_pkg::KIND_RPAREN: begin
        // unwind to the matching paren; none left means an unmatched close
        while (stk_n != 0 && !stop) begin
          stk_n--;
          top = op_stk[stk_n];
          if (top == i2p_pkg::PAREN_MARK) begin
            stop = 1'b1;
          end else begin
            burst[n] = shape(i2p_pkg::OUT_OPERATOR, top, '0, 1'b0, i2p_pkg::ERR_NONE);
            n++;
          end
        end
        if (!stop) begin
          burst[n] = shape(i2p_pkg::OUT_ERROR, '0, '0, 1'b0, i2p_pkg::ERR_RPAREN);
          n++;
        end
        unary_ok = 1'b0;
      end
      i2p_pkg::KIND_OPER: begin
        if (op == i2p_pkg::OP_MINUS && unary_ok) begin
          neg_pending = !neg_pending;
        end else if (op <= i2p_pkg::OP_FACT) begin
          // pop tighter operators, and equal ones unless the newcomer is ^
          while (stk_n != 0 && !stop) begin
            top = op_stk[stk_n - 1];
            if (top != i2p_pkg::PAREN_MARK &&
                (binding_strength(top) > binding_strength(op) ||
                 (binding_strength(top) == binding_strength(op) &&
                  op != i2p_pkg::OP_POWER))) begin
              stk_n--;
              burst[n] = shape(i2p_pkg::OUT_OPERATOR, top, '0, 1'b0, i2p_pkg::ERR_NONE);
              n++;
            end else begin
              stop = 1'b1;
            end
          end
          if (stk_n >= STACK_DEPTH) begin
            burst[n] = shape(i2p_pkg::OUT_ERROR, '0, '0, 1'b0, i2p_pkg::ERR_OVERFLOW);
            n++;
          end else begin
            op_stk[stk_n] = op;
            stk_n++;
            unary_ok = 1'b1;
          end
        end
      end
      i2p_pkg::KIND_END: begin
        // flush top first, skipping parens but remembering them
        while (stk_n != 0) begin
          stk_n--;
          top = op_stk[stk_n];
          if (top == i2p_pkg::PAREN_MARK) begin
            open_seen = 1'b1;
          end else begin
            burst[n] = shape(i2p_pkg::OUT_OPERATOR, top, '0, 1'b0, i2p_pkg::ERR_NONE);
            n++;
          end
        end
        if (open_seen) begin
          burst[n] = shape(i2p_pkg::OUT_ERROR, '0, '0, 1'b0, i2p_pkg::ERR_LPAREN);
          n++;
        end
        clear_predictor();
      end
      default: ;
    endcase
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n - 1) begin
        burst[i].last = 1'b1;
      end
      postfix_q.push_back(burst[i]);
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  token_t      token_q [$];
  int unsigned live_tokens = 0;  // tokens the block acts on
  logic        calm_run  = 1'b0;
  logic        hold_next = 1'b0;

  task automatic add_token(input logic [i2p_pkg::KIND_W-1:0] kind,
                           input logic [i2p_pkg::OP_W-1:0] op,
                           input logic [i2p_pkg::TAG_FIELD_W-1:0] tag);
    token_t t;
    t.kind = kind;
    t.op   = op;
    t.tag  = tag;
    t.hold = hold_next;
    t.calm = calm_run;
    hold_next = 1'b0;
    token_q.push_back(t);
    if (!(kind > i2p_pkg::KIND_END ||
          (kind == i2p_pkg::KIND_OPER && op > i2p_pkg::OP_FACT))) begin
      live_tokens++;
    end
  endtask

  task automatic push_operand(input logic [i2p_pkg::TAG_FIELD_W-1:0] tag);
    add_token(i2p_pkg::KIND_OPERAND, 3'($urandom_range(0, 7)), tag);
  endtask

  task automatic push_op(input logic [i2p_pkg::OP_W-1:0] op);
    add_token(i2p_pkg::KIND_OPER, op, 16'($urandom));
  endtask

  task automatic push_kind(input logic [i2p_pkg::KIND_W-1:0] kind);
    add_token(kind, 3'($urandom_range(0, 7)), 16'($urandom));
  endtask

  // term := [-[-]] (operand | '(' expr ')') [!]
  task automatic gen_term(input int unsigned depth);
    int unsigned pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) begin
      push_op(i2p_pkg::OP_MINUS);
    end else if (pick == 1) begin
      push_op(i2p_pkg::OP_MINUS);
      push_op(i2p_pkg::OP_MINUS);
    end
    if (depth < 3 && $urandom_range(0, 3) == 0) begin
      push_kind(i2p_pkg::KIND_LPAREN);
      gen_expr(depth + 1);
      push_kind(i2p_pkg::KIND_RPAREN);
    end else begin
      push_operand(16'($urandom));
    end
    if ($urandom_range(0, 7) == 0) begin
      push_op(i2p_pkg::OP_FACT);
    end
  endtask

  // expr := term (binop term)*
  task automatic gen_expr(input int unsigned depth);
    gen_term(depth);
    repeat ($urandom_range(0, 3)) begin
      push_op(3'($urandom_range(i2p_pkg::OP_PLUS, i2p_pkg::OP_POWER)));
      gen_term(depth);
    end
  endtask

  // a ^ b ^ ... : right-associative, so every operator stays stacked
  task automatic push_chain(input int unsigned len, input logic close_rparen);
    push_operand(16'($urandom));
    repeat (len) begin
      push_op(i2p_pkg::OP_POWER);
      push_operand(16'($urandom));
    end
    if (close_rparen) begin
      push_kind(i2p_pkg::KIND_RPAREN);
    end
    push_kind(i2p_pkg::KIND_END);
  endtask

  task automatic push_nest(input int unsigned len, input logic with_op);
    repeat (len) begin
      push_kind(i2p_pkg::KIND_LPAREN);
    end
    if (with_op) begin
      push_op(i2p_pkg::OP_PLUS);
    end
    push_operand(16'($urandom));
    push_kind(i2p_pkg::KIND_END);
  endtask

  // ---------------------------------------------------------------------------
  // Source side: drives token beats and predicts on each accepted one
  // ---------------------------------------------------------------------------
  int unsigned src_idle = 0;

  always @(posedge clk) begin : token_source
    token_t      tok;
    int unsigned made;
    made = 0;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_idle      <= 0;
      clear_predictor();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        made = convert_token(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[18:3]);
        predicted_n <= predicted_n + made;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_idle != 0) begin
          s_axis_tvalid <= 1'b0;
          src_idle      <= src_idle - 1;
        end else if (token_q.size() != 0 &&
                     !(token_q[0].hold && predicted_n + made != drained_n)) begin
          tok = token_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'd0, tok.tag, tok.op};
          s_axis_tuser  <= tok.kind;
          src_idle      <= tok.calm ? 0 : $urandom_range(0, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink side: random back-pressure and beat checking
  // ---------------------------------------------------------------------------
  int unsigned sink_idle = 0;

  function automatic void flag_field(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    fail_n++;
  endfunction

  always @(posedge clk) begin : postfix_sink
    postfix_t    got;
    postfix_t    want;
    int unsigned w;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_idle     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tuser;
        got.op   = m_axis_tdata[2:0];
        got.tag  = m_axis_tdata[18:3];
        got.neg  = m_axis_tdata[19];
        got.err  = m_axis_tdata[21:20];
        got.last = m_axis_tlast;
        if (postfix_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got kind %0h op %0h tag %0h err %0h",
                   $time, got.kind, got.op, got.tag, got.err);
          fail_n++;
        end else begin
          want = postfix_q.pop_front();
          drained_n <= drained_n + 1;
          if (got.kind !== want.kind) flag_field("out_kind", want.kind, got.kind);
          if (got.op !== want.op) flag_field("out_op", want.op, got.op);
          if (got.tag !== want.tag) flag_field("out_tag", want.tag, got.tag);
          if (got.neg !== want.neg) flag_field("negated", want.neg, got.neg);
          if (got.err !== want.err) flag_field("error_code", want.err, got.err);
          if (got.last !== want.last) flag_field("last", want.last, got.last);
        end
        // a quarter of the time the sink never stalls
        w = ((drained_n % 96) < 24) ? 0 : $urandom_range(0, 3);
        m_axis_tready <= (w == 0);
        sink_idle     <= w;
      end else if (sink_idle != 0) begin
        sink_idle     <= sink_idle - 1;
        m_axis_tready <= (sink_idle == 1);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    wait (cycle_n >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles", $time, cycle_n);
    $display("FAIL infix_to_postfix_converter");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    int unsigned target;
    int unsigned seq_n;
    int unsigned pick;
    // directed: tag extremes, binary and unary minus, cancelling minuses,
    // negation across a paren, right-associative ^, !, pops on *, unknown codes,
    // unmatched close, open paren left at end, end on an empty stack
    push_operand(16'hFFFF);
    push_op(i2p_pkg::OP_MINUS);
    push_op(i2p_pkg::OP_MINUS);
    push_op(i2p_pkg::OP_MINUS);
    push_op(i2p_pkg::OP_MINUS);
    push_kind(i2p_pkg::KIND_LPAREN);
    push_operand(16'h0000);
    push_op(i2p_pkg::OP_POWER);
    push_operand(16'h5A5A);
    push_op(i2p_pkg::OP_POWER);
    push_operand(16'hA5A5);
    push_op(i2p_pkg::OP_FACT);
    push_op(i2p_pkg::OP_TIMES);
    push_operand(16'h8001);
    push_kind(i2p_pkg::KIND_RPAREN);
    push_op(i2p_pkg::OP_DIVIDE);
    add_token(i2p_pkg::KIND_OPER, BAD_OP, 16'h1234);
    push_operand(16'h7FFE);
    push_kind(i2p_pkg::KIND_RPAREN);
    push_op(i2p_pkg::OP_PLUS);
    add_token(BAD_KIND, i2p_pkg::OP_FACT, 16'hFFFF);
    push_kind(i2p_pkg::KIND_LPAREN);
    push_kind(i2p_pkg::KIND_END);
    push_kind(i2p_pkg::KIND_END);

    // stack overflow on a paren and on an operator, the full 17-beat burst,
    // then random traffic up to the item total
    target    = TOTAL_ITEMS;
    hold_next = 1'b1;
    push_nest(STACK_DEPTH + 1, 1'b1);
    push_chain(STACK_DEPTH, 1'b1);
    seq_n = 0;
    while (live_tokens < target) begin
      calm_run = ($urandom_range(0, 3) == 0);
      if (seq_n % 8 == 7) begin
        hold_next = 1'b1;
      end
      pick = $urandom_range(0, 9);
      case (pick)
        0: push_nest($urandom_range(12, 18), 1'($urandom_range(0, 1)));
        1: push_chain($urandom_range(12, 18), 1'($urandom_range(0, 1)));
        2: begin
          // raw noise, unknown codes included
          repeat ($urandom_range(1, 6)) begin
            add_token(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 16'($urandom));
          end
        end
        3: begin
          // missing close paren
          push_kind(i2p_pkg::KIND_LPAREN);
          gen_expr(0);
          push_kind(i2p_pkg::KIND_END);
        end
        4: begin
          // stray close paren
          gen_expr(0);
          push_kind(i2p_pkg::KIND_RPAREN);
          push_kind(i2p_pkg::KIND_END);
        end
        default: begin
          gen_expr(0);
          push_kind(i2p_pkg::KIND_END);
        end
      endcase
      seq_n++;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // drain: all tokens sent and every predicted beat seen
    do begin
      @(negedge clk);
    end while (token_q.size() != 0 || s_axis_tvalid || predicted_n != drained_n);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_n == 0 && postfix_q.size() == 0) begin
      $display("PASS infix_to_postfix_converter");
    end else begin
      $display("FAIL infix_to_postfix_converter");
    end
    $finish;
  end

endmodule
